[hw/rtl/assert_macros.svh]
// assertion macros shared by the slot table rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define STA_ASSERT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define STA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[hw/rtl/sta_pkg.sv]
// shared types and constants of the slot table allocator
package sta_pkg;

   localparam int SLOTS_DEF      = 64;
   localparam int VALUE_BITS_DEF = 32;

   localparam int OP_W     = 3;
   localparam int POS_W    = 7;
   localparam int VAL_W    = 32;
   localparam int STATUS_W = 2;
   localparam int RPOS_W   = 6;
   localparam int CNT_W    = 7;

   typedef enum logic [OP_W-1:0] {
      OP_ADD    = 3'd0,
      OP_SET    = 3'd1,
      OP_DELETE = 3'd2,
      OP_NEXT   = 3'd3,
      OP_PREV   = 3'd4,
      OP_CLEAR  = 3'd5,
      OP_READ   = 3'd6
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK   = 2'd0,
      STAT_NONE = 2'd1,
      STAT_BAD  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_EXEC = 2'd1,
      S_READ = 2'd2
   } state_type;

   typedef struct packed {
      logic capture;
      logic execute;
      logic finish;
   } ctl_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_status_type;

endpackage

[hw/rtl/sta_req_if.sv]
// request channel interface
interface sta_req_if;
   logic                            valid;
   logic                            ready;
   logic [sta_pkg::OP_W-1:0]        operation;
   logic signed [sta_pkg::POS_W-1:0] position;
   logic [sta_pkg::VAL_W-1:0]       value;

   modport source (output valid, output operation, output position, output value,
                   input ready);
   modport sink (input valid, input operation, input position, input value,
                 output ready);
endinterface

[hw/rtl/sta_rsp_if.sv]
// response channel interface
interface sta_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [sta_pkg::STATUS_W-1:0]  status;
   logic [sta_pkg::RPOS_W-1:0]    result_position;
   logic                          found;
   logic [sta_pkg::VAL_W-1:0]     read_value;
   logic [sta_pkg::CNT_W-1:0]     occupied_count;

   modport source (output valid, output status, output result_position, output found,
                   output read_value, output occupied_count, input ready);
   modport sink (input valid, input status, input result_position, input found,
                 input read_value, input occupied_count, output ready);
endinterface

[hw/rtl/sta_control.sv]
// controller state machine of the slot table allocator
`include "assert_macros.svh"
module sta_control (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  sta_pkg::dp_status_type status,
   output sta_pkg::ctl_cmd_type   cmd
);
   import sta_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_READ;
         end
         S_READ: begin
            if (status.out_free) state_in = req_valid ? S_EXEC : S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_ready   = 1'b0;
      cmd.execute = 1'b0;
      cmd.finish  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
         end
         S_EXEC: begin
            cmd.execute = 1'b1;
         end
         S_READ: begin
            req_ready  = status.out_free;
            cmd.finish = status.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
      cmd.capture = req_valid && req_ready;
   end

   `STA_ASSERT_NEXT(a_exec_then_read, clock, reset, state_ff == S_EXEC, state_ff == S_READ)
   `STA_ASSERT(a_capture_state, clock, reset, cmd.capture,
      state_ff == S_IDLE || state_ff == S_READ)

endmodule

[hw/rtl/sta_datapath.sv]
// datapath: occupancy vector, value memory, searches and response register
`include "assert_macros.svh"
module sta_datapath #(
   parameter int SLOTS      = sta_pkg::SLOTS_DEF,
   parameter int VALUE_BITS = sta_pkg::VALUE_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  sta_pkg::ctl_cmd_type             cmd,
   output sta_pkg::dp_status_type           status,
   input  logic [sta_pkg::OP_W-1:0]         req_operation,
   input  logic signed [sta_pkg::POS_W-1:0] req_position,
   input  logic [sta_pkg::VAL_W-1:0]        req_value,
   sta_rsp_if.source                        rsp_ch
);
   import sta_pkg::*;

   localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int NUM_W  = $clog2(SLOTS + 1);
   localparam int SW     = (VALUE_BITS < VAL_W) ? VALUE_BITS : VAL_W;

   function automatic logic [IDX_W-1:0] lowest_set(input logic [SLOTS-1:0] v);
      logic [IDX_W-1:0] idx;
      idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (v[i]) idx = IDX_W'(i);
      end
      return idx;
   endfunction

   function automatic logic [IDX_W-1:0] highest_set(input logic [SLOTS-1:0] v);
      logic [IDX_W-1:0] idx;
      idx = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (v[i]) idx = IDX_W'(i);
      end
      return idx;
   endfunction

   // captured transaction
   logic [OP_W-1:0]         op_ff;
   logic signed [POS_W-1:0] pos_ff;
   logic [SW-1:0]           val_ff;

   // table state
   logic [SLOTS-1:0] occ_ff, occ_in;
   logic [NUM_W-1:0] cnt_ff, cnt_in;
   logic [IDX_W-1:0] ss_ff, ss_in;
   logic [SW-1:0]    mem [SLOTS];
   logic [SW-1:0]    rdata_ff;

   // result of the execute cycle
   status_type       res_status_ff, res_status_in;
   logic [IDX_W-1:0] res_pos_ff, res_pos_in;
   logic             res_found_ff, res_found_in;
   logic [SW-1:0]    res_val_ff, res_val_in;
   logic             res_rd_ff, res_rd_in;

   // response register
   logic               out_valid_ff;
   status_type         out_status_ff;
   logic [RPOS_W-1:0]  out_pos_ff;
   logic               out_found_ff;
   logic [VAL_W-1:0]   out_val_ff;
   logic [CNT_W-1:0]   out_cnt_ff;

   logic             mem_we, mem_re;
   logic [IDX_W-1:0] mem_waddr, mem_raddr;

   logic             val_nz, in_range, slot_occ, full;
   logic [IDX_W-1:0] pidx, add_idx, next_idx, prev_idx;
   logic [SLOTS-1:0] empty_v, add_hi_v, next_v, prev_v;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= req_operation;
         pos_ff <= req_position;
         val_ff <= req_value[SW-1:0];
      end
   end

   // operand decode and searches
   always_comb begin
      val_nz   = |val_ff;
      in_range = !pos_ff[POS_W-1] && (int'(pos_ff) < SLOTS);
      pidx     = IDX_W'($unsigned(pos_ff));
      slot_occ = occ_ff[pidx];
      empty_v  = ~occ_ff;
      full     = ~|empty_v;
      for (int i = 0; i < SLOTS; i++) begin
         add_hi_v[i] = empty_v[i] && (IDX_W'(i) >= ss_ff);
         next_v[i]   = occ_ff[i] && (int'(pos_ff) < i);
         prev_v[i]   = occ_ff[i] && (pos_ff[POS_W-1] || (int'(pos_ff) > i));
      end
      add_idx  = (|add_hi_v) ? lowest_set(add_hi_v) : lowest_set(empty_v);
      next_idx = lowest_set(next_v);
      prev_idx = highest_set(prev_v);
   end

   // execute: state update and memory access
   always_comb begin
      occ_in        = occ_ff;
      cnt_in        = cnt_ff;
      ss_in         = ss_ff;
      res_status_in = res_status_ff;
      res_pos_in    = res_pos_ff;
      res_found_in  = res_found_ff;
      res_val_in    = res_val_ff;
      res_rd_in     = res_rd_ff;
      mem_we        = 1'b0;
      mem_waddr     = pidx;
      mem_re        = 1'b0;
      mem_raddr     = pidx;
      if (cmd.execute) begin
         res_status_in = STAT_OK;
         res_pos_in    = '0;
         res_found_in  = 1'b0;
         res_val_in    = '0;
         res_rd_in     = 1'b0;
         case (op_type'(op_ff))
            OP_ADD: begin
               if (!val_nz) begin
                  res_status_in = STAT_BAD;
               end else if (full) begin
                  res_status_in = STAT_NONE;
               end else begin
                  mem_we          = 1'b1;
                  mem_waddr       = add_idx;
                  occ_in[add_idx] = 1'b1;
                  cnt_in          = cnt_ff + NUM_W'(1);
                  ss_in           = (add_idx == IDX_W'(SLOTS - 1)) ? '0
                                                                    : add_idx + IDX_W'(1);
                  res_found_in    = 1'b1;
                  res_pos_in      = add_idx;
                  res_val_in      = val_ff;
               end
            end
            OP_SET: begin
               if (!in_range) begin
                  res_status_in = STAT_BAD;
               end else begin
                  mem_we       = 1'b1;
                  occ_in[pidx] = val_nz;
                  if (!slot_occ && val_nz) cnt_in = cnt_ff + NUM_W'(1);
                  if (slot_occ && !val_nz) cnt_in = cnt_ff - NUM_W'(1);
                  res_found_in = val_nz;
                  res_pos_in   = val_nz ? pidx : '0;
                  res_val_in   = val_ff;
               end
            end
            OP_DELETE: begin
               if (!in_range || !slot_occ) begin
                  res_status_in = STAT_BAD;
               end else begin
                  occ_in[pidx] = 1'b0;
                  cnt_in       = cnt_ff - NUM_W'(1);
               end
            end
            OP_NEXT: begin
               if (|next_v) begin
                  mem_re       = 1'b1;
                  mem_raddr    = next_idx;
                  res_found_in = 1'b1;
                  res_pos_in   = next_idx;
                  res_rd_in    = 1'b1;
               end else begin
                  res_status_in = STAT_NONE;
               end
            end
            OP_PREV: begin
               if (|prev_v) begin
                  mem_re       = 1'b1;
                  mem_raddr    = prev_idx;
                  res_found_in = 1'b1;
                  res_pos_in   = prev_idx;
                  res_rd_in    = 1'b1;
               end else begin
                  res_status_in = STAT_NONE;
               end
            end
            OP_CLEAR: begin
               occ_in = '0;
               cnt_in = '0;
            end
            OP_READ: begin
               if (!in_range || !slot_occ) begin
                  res_status_in = STAT_BAD;
               end else begin
                  mem_re       = 1'b1;
                  res_found_in = 1'b1;
                  res_pos_in   = pidx;
                  res_rd_in    = 1'b1;
               end
            end
            default: begin
               res_status_in = STAT_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
         cnt_ff <= '0;
         ss_ff  <= '0;
      end else begin
         occ_ff <= occ_in;
         cnt_ff <= cnt_in;
         ss_ff  <= ss_in;
      end
   end

   always_ff @(posedge clock) begin
      res_status_ff <= res_status_in;
      res_pos_ff    <= res_pos_in;
      res_found_ff  <= res_found_in;
      res_val_ff    <= res_val_in;
      res_rd_ff     <= res_rd_in;
   end

   // value store
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= val_ff;
      if (mem_re) rdata_ff <= mem[mem_raddr];
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         out_status_ff <= res_status_ff;
         out_pos_ff    <= RPOS_W'(res_pos_ff);
         out_found_ff  <= res_found_ff;
         out_val_ff    <= VAL_W'(res_rd_ff ? rdata_ff : res_val_ff);
         out_cnt_ff    <= CNT_W'(cnt_ff);
      end
   end

   assign status.out_free        = !out_valid_ff || rsp_ch.ready;
   assign rsp_ch.valid           = out_valid_ff;
   assign rsp_ch.status          = out_status_ff;
   assign rsp_ch.result_position = out_pos_ff;
   assign rsp_ch.found           = out_found_ff;
   assign rsp_ch.read_value      = out_val_ff;
   assign rsp_ch.occupied_count  = out_cnt_ff;

   `STA_ASSERT(a_count_tracks_occ, clock, reset, 1'b1, int'(cnt_ff) == $countones(occ_ff))
   `STA_ASSERT(a_empty_rsp_zero, clock, reset, out_valid_ff && !out_found_ff,
      out_pos_ff == '0 && out_val_ff == '0)
   `STA_ASSERT_NEXT(a_finish_loads, clock, reset, cmd.finish, out_valid_ff)

endmodule

[hw/rtl/slot_table_next_fit_allocator.sv]
// top level of the slot table with next-fit handle allocation
//
//   channel  direction  handshake        payload
//   req_ch   in         valid / ready    operation, position, value
//   rsp_ch   out        valid / ready    status, result_position, found,
//                                        read_value, occupied_count
//
// an execute step searches the occupancy vector and updates the table,
// then a read step waits for the registered value memory read to return
// a new transaction is taken in the cycle the previous response is loaded
// reset clears the occupancy vector, count and search start
// a stalled response holds the block in its read cycle until taken
module slot_table_next_fit_allocator #(
   parameter int SLOTS      = sta_pkg::SLOTS_DEF,
   parameter int VALUE_BITS = sta_pkg::VALUE_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   sta_req_if.sink    req_ch,
   sta_rsp_if.source  rsp_ch
);
   import sta_pkg::*;

   ctl_cmd_type   cmd;
   dp_status_type dp_status;
   logic          ready;

   sta_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (ready),
      .status    (dp_status),
      .cmd       (cmd)
   );

   sta_datapath #(
      .SLOTS      (SLOTS),
      .VALUE_BITS (VALUE_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (dp_status),
      .req_operation (req_ch.operation),
      .req_position  (req_ch.position),
      .req_value     (req_ch.value),
      .rsp_ch        (rsp_ch)
   );

   assign req_ch.ready = ready;

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// testbench for the slot table allocator: random and directed ops checked against a predictor
module tb_top;
   import sta_pkg::*;

   localparam int TABLE_SLOTS = SLOTS_DEF;
   localparam int RANDOM_OPS  = 1850;

   typedef struct {
      op_type              op;
      logic signed [POS_W-1:0] pos;
      logic [VAL_W-1:0]    val;
      bit                  drain_first;
   } slot_op_type;

   typedef struct {
      status_type          status;
      logic [RPOS_W-1:0]   result_position;
      logic                found;
      logic [VAL_W-1:0]    read_value;
      logic [CNT_W-1:0]    occupied_count;
   } slot_reply_type;

   logic clock;
   logic reset;

   sta_req_if req_ch ();
   sta_rsp_if rsp_ch ();

   slot_table_next_fit_allocator dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   slot_op_type    queued_ops[$];
   slot_reply_type awaited_replies[$];

   logic [VAL_W-1:0] table_values [TABLE_SLOTS];
   int               alloc_cursor;
   int               used_count;

   int unsigned cycle_count;
   int          mismatch_count;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // predicted table behavior for one transaction
   function automatic slot_reply_type apply_slot_op(op_type op, logic signed [POS_W-1:0] pos,
                                                    logic [VAL_W-1:0] val);
      slot_reply_type r;
      int p;
      int idx;
      int hit;
      bit in_range;
      r.status          = STAT_OK;
      r.result_position = '0;
      r.found           = 1'b0;
      r.read_value      = '0;
      p        = int'(pos);
      in_range = (p >= 0) && (p < TABLE_SLOTS);
      case (op)
         OP_ADD: begin
            if (val == '0) begin
               r.status = STAT_BAD;
            end else begin
               hit = -1;
               idx = alloc_cursor;
               for (int n = 0; n < TABLE_SLOTS; n++) begin
                  if (hit < 0 && table_values[idx] == '0) hit = idx;
                  idx = (idx + 1) % TABLE_SLOTS;
               end
               if (hit < 0) begin
                  r.status = STAT_NONE;
               end else begin
                  table_values[hit] = val;
                  used_count++;
                  alloc_cursor      = (hit + 1) % TABLE_SLOTS;
                  r.result_position = hit[RPOS_W-1:0];
                  r.found           = 1'b1;
                  r.read_value      = val;
               end
            end
         end
         OP_SET: begin
            if (!in_range) begin
               r.status = STAT_BAD;
            end else begin
               if (table_values[p] == '0 && val != '0) used_count++;
               if (table_values[p] != '0 && val == '0) used_count--;
               table_values[p] = val;
               if (val != '0) begin
                  r.found           = 1'b1;
                  r.result_position = p[RPOS_W-1:0];
                  r.read_value      = val;
               end
            end
         end
         OP_DELETE: begin
            if (!in_range || table_values[p] == '0) begin
               r.status = STAT_BAD;
            end else begin
               table_values[p] = '0;
               used_count--;
            end
         end
         OP_NEXT: begin
            r.status = STAT_NONE;
            for (idx = ((p < -1) ? -1 : p) + 1; idx < TABLE_SLOTS; idx++) begin
               if (table_values[idx] != '0) begin
                  r.status          = STAT_OK;
                  r.found           = 1'b1;
                  r.result_position = idx[RPOS_W-1:0];
                  r.read_value      = table_values[idx];
                  break;
               end
            end
         end
         OP_PREV: begin
            r.status = STAT_NONE;
            idx = (p < 0 || p > TABLE_SLOTS) ? TABLE_SLOTS : p;
            for (idx = idx - 1; idx >= 0; idx--) begin
               if (table_values[idx] != '0) begin
                  r.status          = STAT_OK;
                  r.found           = 1'b1;
                  r.result_position = idx[RPOS_W-1:0];
                  r.read_value      = table_values[idx];
                  break;
               end
            end
         end
         OP_CLEAR: begin
            for (int n = 0; n < TABLE_SLOTS; n++) table_values[n] = '0;
            used_count = 0;
         end
         OP_READ: begin
            if (!in_range || table_values[p] == '0) begin
               r.status = STAT_BAD;
            end else begin
               r.found           = 1'b1;
               r.result_position = p[RPOS_W-1:0];
               r.read_value      = table_values[p];
            end
         end
         default: ;
      endcase
      r.occupied_count = used_count[CNT_W-1:0];
      return r;
   endfunction

   // idle about a third of the time, except in a quiet window of each period
   function automatic bit take_gap();
      return (cycle_count % 5000 >= 1200) && ($urandom_range(0, 99) < 33);
   endfunction

   task automatic queue_op(op_type op, int pos, logic [VAL_W-1:0] val);
      slot_op_type t;
      t.op          = op;
      t.pos         = POS_W'(pos);
      t.val         = val;
      t.drain_first = 1'b0;
      queued_ops.push_back(t);
   endtask

   task automatic queue_drain();
      slot_op_type t;
      t.op          = OP_READ;
      t.pos         = '0;
      t.val         = '0;
      t.drain_first = 1'b1;
      queued_ops.push_back(t);
   endtask

   function automatic int rand_pos();
      int r;
      r = $urandom_range(0, 99);
      if (r < 5) return -1;
      if (r < 8) return -int'($urandom_range(2, 64));
      return int'($urandom_range(0, TABLE_SLOTS - 1));
   endfunction

   function automatic logic [VAL_W-1:0] rand_val();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) return '0;
      if (r < 12) return 32'd1;
      if (r < 16) return 32'hFFFF_FFFF;
      return $urandom();
   endfunction

   task automatic queue_random(int mode);
      int r;
      r = $urandom_range(0, 99);
      case (mode)
         0: begin
            if (r < 80) queue_op(OP_ADD, rand_pos(), rand_val());
            else        queue_op(OP_READ, rand_pos(), '0);
         end
         1: begin
            if (r < 25)      queue_op(OP_ADD, rand_pos(), rand_val());
            else if (r < 40) queue_op(OP_SET, rand_pos(), rand_val());
            else if (r < 60) queue_op(OP_DELETE, rand_pos(), rand_val());
            else if (r < 70) queue_op(OP_NEXT, rand_pos(), rand_val());
            else if (r < 80) queue_op(OP_PREV, rand_pos(), rand_val());
            else if (r < 99) queue_op(OP_READ, rand_pos(), rand_val());
            else             queue_op(OP_CLEAR, rand_pos(), rand_val());
         end
         2: begin
            if (r < 35)      queue_op(OP_NEXT, rand_pos(), rand_val());
            else if (r < 70) queue_op(OP_PREV, rand_pos(), rand_val());
            else if (r < 90) queue_op(OP_READ, rand_pos(), rand_val());
            else             queue_op(OP_ADD, rand_pos(), rand_val());
         end
         default: begin
            if (r < 70)      queue_op(OP_DELETE, rand_pos(), rand_val());
            else if (r < 85) queue_op(OP_SET, rand_pos(), '0);
            else             queue_op(OP_NEXT, rand_pos(), rand_val());
         end
      endcase
   endtask

   task automatic note_mismatch(string what, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch %0d at %0t: %s expected %0h actual %0h",
                  mismatch_count, $realtime, what, want, got);
   endtask

   always @(posedge clock) begin
      if (reset) cycle_count <= 0;
      else       cycle_count <= cycle_count + 1;
   end

   // driver
   always @(posedge clock) begin : driver
      slot_op_type t;
      bit          holding;
      bit          next_valid;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         holding = req_ch.valid && !req_ch.ready;
         if (req_ch.valid && req_ch.ready)
            awaited_replies.push_back(apply_slot_op(op_type'(req_ch.operation),
                                                    req_ch.position, req_ch.value));
         if (!holding) begin
            next_valid = 1'b0;
            if (queued_ops.size() > 0 && queued_ops[0].drain_first) begin
               if (awaited_replies.size() == 0 && !req_ch.valid) void'(queued_ops.pop_front());
            end else if (queued_ops.size() > 0 && !take_gap()) begin
               t = queued_ops.pop_front();
               req_ch.operation <= t.op;
               req_ch.position  <= t.pos;
               req_ch.value     <= t.val;
               next_valid = 1'b1;
            end
            req_ch.valid <= next_valid;
         end
      end
   end

   // monitor
   always @(posedge clock) begin : monitor
      slot_reply_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (awaited_replies.size() == 0) begin
               note_mismatch("response with nothing pending", '0, rsp_ch.read_value);
            end else begin
               want = awaited_replies.pop_front();
               if (rsp_ch.status !== want.status)
                  note_mismatch("status", VAL_W'(want.status), VAL_W'(rsp_ch.status));
               if (rsp_ch.result_position !== want.result_position)
                  note_mismatch("result_position", VAL_W'(want.result_position),
                                VAL_W'(rsp_ch.result_position));
               if (rsp_ch.found !== want.found)
                  note_mismatch("found", VAL_W'(want.found), VAL_W'(rsp_ch.found));
               if (rsp_ch.read_value !== want.read_value)
                  note_mismatch("read_value", want.read_value, rsp_ch.read_value);
               if (rsp_ch.occupied_count !== want.occupied_count)
                  note_mismatch("occupied_count", VAL_W'(want.occupied_count),
                                VAL_W'(rsp_ch.occupied_count));
            end
         end
         rsp_ch.ready <= !take_gap();
      end
   end

   initial begin
      #10_000_000;
      $display("Some tests failed");
      $finish;
   end

   initial begin : stimulus
      int made;
      int mode;
      int run;
      clock            = 1'b0;
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.operation = OP_READ;
      req_ch.position  = '0;
      req_ch.value     = '0;
      rsp_ch.ready     = 1'b0;
      mismatch_count   = 0;
      cycle_count      = 0;
      alloc_cursor     = 0;
      used_count       = 0;
      for (int n = 0; n < TABLE_SLOTS; n++) table_values[n] = '0;

      // directed
      queue_op(OP_READ,   0,   '0);
      queue_op(OP_ADD,    0,   '0);
      queue_op(OP_ADD,    0,   32'hFFFF_FFFF);
      queue_op(OP_ADD,    -64, 32'd1);
      queue_op(OP_SET,    63,  32'h8000_0000);
      queue_op(OP_SET,    -1,  32'd5);
      queue_op(OP_NEXT,   -1,  '0);
      queue_op(OP_NEXT,   -64, '0);
      queue_op(OP_NEXT,   63,  '0);
      queue_op(OP_PREV,   -1,  '0);
      queue_op(OP_PREV,   -64, '0);
      queue_op(OP_PREV,   0,   '0);
      queue_op(OP_READ,   63,  '0);
      queue_op(OP_DELETE, 1,   '0);
      queue_op(OP_DELETE, 1,   '0);
      queue_op(OP_DELETE, -64, '0);
      queue_op(OP_READ,   -1,  '0);
      queue_op(OP_SET,    1,   '0);
      queue_op(OP_SET,    0,   '0);
      queue_op(OP_SET,    5,   32'h0001_2345);
      queue_op(OP_SET,    5,   32'h55AA_55AA);
      queue_op(OP_CLEAR,  0,   '0);
      queue_op(OP_NEXT,   -1,  '0);
      queue_op(OP_ADD,    0,   32'h0000_0007);
      queue_op(OP_PREV,   63,  '0);
      queue_drain();

      // fill past capacity so the full case is reached early
      for (int n = 0; n < 70; n++) queue_op(OP_ADD, rand_pos(), $urandom() | 32'd1);
      made = 70;
      while (made < RANDOM_OPS) begin
         mode = $urandom_range(0, 9);
         if (mode == 9) begin
            queue_op(OP_CLEAR, rand_pos(), rand_val());
            queue_drain();
            made++;
         end else begin
            run = $urandom_range(20, 70);
            for (int n = 0; n < run; n++)
               queue_random(mode < 3 ? 0 : mode < 6 ? 1 : mode < 8 ? 2 : 3);
            made += run;
         end
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock);
      while (queued_ops.size() != 0 || req_ch.valid || awaited_replies.size() != 0);
      repeat (10) @(posedge clock);

      if (mismatch_count == 0 && awaited_replies.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
